FILE: design/siu_pkg.sv
`timescale 1ns / 1ps

package siu_pkg;

    localparam int QUOT_BITS = 32;

    typedef struct packed {
        logic hit;
        logic par;
    } siu_flags_t;

    localparam logic [QUOT_BITS-1:0] SAT_POS = {1'b0, {(QUOT_BITS-1){1'b1}}};
    localparam logic [QUOT_BITS-1:0] SAT_NEG = {1'b1, {(QUOT_BITS-1){1'b0}}};

endpackage

FILE: design/siu_solve.sv
`timescale 1ns / 1ps

module siu_solve import siu_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  a_x1,
    input  logic signed [COORD_BITS-1:0]  a_y1,
    input  logic signed [COORD_BITS-1:0]  a_x2,
    input  logic signed [COORD_BITS-1:0]  a_y2,
    input  logic signed [COORD_BITS-1:0]  b_x1,
    input  logic signed [COORD_BITS-1:0]  b_y1,
    input  logic signed [COORD_BITS-1:0]  b_x2,
    input  logic signed [COORD_BITS-1:0]  b_y2,
    output logic                          out_valid,
    output siu_flags_t                    out_flags,
    output logic signed [2*COORD_BITS+2:0] out_det,
    output logic signed [2*COORD_BITS+2:0] out_t1,
    output logic signed [2*COORD_BITS+3:0] out_dt,
    output logic signed [COORD_BITS-1:0]  out_x1,
    output logic signed [COORD_BITS-1:0]  out_x2,
    output logic signed [COORD_BITS-1:0]  out_y1,
    output logic signed [COORD_BITS-1:0]  out_y2
);

    localparam int C   = COORD_BITS;
    localparam int DFW = C + 1;
    localparam int PW  = 2 * C + 2;
    localparam int DW  = 2 * C + 3;

    logic [3:0] v_reg;

    logic signed [DFW-1:0] m00_reg, m10_reg, m01_reg, m11_reg, tx_reg, ty_reg;
    logic signed [PW-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DW-1:0]  det_reg, t1_reg, t2_reg;
    logic signed [DW-1:0]  det_d_reg, t1_d_reg;
    logic signed [DW:0]    dt_reg;
    siu_flags_t            flags_reg;
    logic signed [C-1:0]   x1_reg [4];
    logic signed [C-1:0]   x2_reg [4];
    logic signed [C-1:0]   y1_reg [4];
    logic signed [C-1:0]   y2_reg [4];

    logic       pos;
    siu_flags_t flags_next;

    always_comb begin
        pos            = (det_reg > 0);
        if (pos) begin
            flags_next.hit = (t1_reg >= 0) && (t1_reg <= det_reg)
                          && (t2_reg >= 0) && (t2_reg <= det_reg);
        end else begin
            flags_next.hit = (t1_reg >= det_reg) && (t1_reg <= 0)
                          && (t2_reg >= det_reg) && (t2_reg <= 0);
        end
        flags_next.par = (det_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // differences
            m00_reg <= DFW'(a_x1) - DFW'(a_x2);
            m10_reg <= DFW'(a_y1) - DFW'(a_y2);
            m01_reg <= DFW'(b_x2) - DFW'(b_x1);
            m11_reg <= DFW'(b_y2) - DFW'(b_y1);
            tx_reg  <= DFW'(b_x2) - DFW'(a_x2);
            ty_reg  <= DFW'(b_y2) - DFW'(a_y2);
            // products
            p0_reg <= PW'(m00_reg) * PW'(m11_reg);
            p1_reg <= PW'(m01_reg) * PW'(m10_reg);
            p2_reg <= PW'(m11_reg) * PW'(tx_reg);
            p3_reg <= PW'(m01_reg) * PW'(ty_reg);
            p4_reg <= PW'(m00_reg) * PW'(ty_reg);
            p5_reg <= PW'(m10_reg) * PW'(tx_reg);
            // determinant and scaled parameters
            det_reg <= DW'(p0_reg) - DW'(p1_reg);
            t1_reg  <= DW'(p2_reg) - DW'(p3_reg);
            t2_reg  <= DW'(p4_reg) - DW'(p5_reg);
            // bounds test
            det_d_reg <= det_reg;
            t1_d_reg  <= t1_reg;
            dt_reg    <= (DW+1)'(det_reg) - (DW+1)'(t1_reg);
            flags_reg <= flags_next;
            x1_reg[0] <= a_x1;
            x2_reg[0] <= a_x2;
            y1_reg[0] <= a_y1;
            y2_reg[0] <= a_y2;
            for (int i = 1; i < 4; i++) begin
                x1_reg[i] <= x1_reg[i-1];
                x2_reg[i] <= x2_reg[i-1];
                y1_reg[i] <= y1_reg[i-1];
                y2_reg[i] <= y2_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[3];
    assign out_flags = flags_reg;
    assign out_det   = det_d_reg;
    assign out_t1    = t1_d_reg;
    assign out_dt    = dt_reg;
    assign out_x1    = x1_reg[3];
    assign out_x2    = x2_reg[3];
    assign out_y1    = y1_reg[3];
    assign out_y2    = y2_reg[3];

endmodule

FILE: design/siu_project.sv
`timescale 1ns / 1ps

module siu_project import siu_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int EXTRA_FRAC_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  siu_flags_t                     in_flags,
    input  logic signed [2*COORD_BITS+2:0] det,
    input  logic signed [2*COORD_BITS+2:0] t1,
    input  logic signed [2*COORD_BITS+3:0] dt,
    input  logic signed [COORD_BITS-1:0]   x1,
    input  logic signed [COORD_BITS-1:0]   x2,
    input  logic signed [COORD_BITS-1:0]   y1,
    input  logic signed [COORD_BITS-1:0]   y2,
    output logic                           out_valid,
    output siu_flags_t                     out_flags,
    output logic [3*COORD_BITS+4+EXTRA_FRAC_BITS:0] out_num_x,
    output logic [3*COORD_BITS+4+EXTRA_FRAC_BITS:0] out_num_y,
    output logic                           out_neg_x,
    output logic                           out_neg_y,
    output logic [2*COORD_BITS+2:0]        out_dmag
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int MW = C + DW + 1;
    localparam int NS = C + DW + 2;
    localparam int NW = NS + EXTRA_FRAC_BITS;

    logic [1:0] v_reg;

    logic signed [MW-1:0] px1_reg, px2_reg, py1_reg, py2_reg;
    logic signed [DW-1:0] det_reg;
    siu_flags_t           fl0_reg, fl1_reg;
    logic [NW-1:0]        nx_reg, ny_reg;
    logic                 negx_reg, negy_reg;
    logic [DW-1:0]        dmag_reg;

    logic signed [NW-1:0] sx, sy;
    logic                 dneg;

    always_comb begin
        sx   = (NW'(px1_reg) + NW'(px2_reg)) <<< EXTRA_FRAC_BITS;
        sy   = (NW'(py1_reg) + NW'(py2_reg)) <<< EXTRA_FRAC_BITS;
        dneg = det_reg[DW-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg  <= MW'(x1) * MW'(t1);
            px2_reg  <= MW'(x2) * MW'(dt);
            py1_reg  <= MW'(y1) * MW'(t1);
            py2_reg  <= MW'(y2) * MW'(dt);
            det_reg  <= det;
            fl0_reg  <= in_flags;
            nx_reg   <= sx[NW-1] ? NW'(-sx) : NW'(sx);
            ny_reg   <= sy[NW-1] ? NW'(-sy) : NW'(sy);
            negx_reg <= sx[NW-1] ^ dneg;
            negy_reg <= sy[NW-1] ^ dneg;
            dmag_reg <= dneg ? DW'(-det_reg) : DW'(det_reg);
            fl1_reg  <= fl0_reg;
        end
    end

    assign out_valid = v_reg[1];
    assign out_flags = fl1_reg;
    assign out_num_x = nx_reg;
    assign out_num_y = ny_reg;
    assign out_neg_x = negx_reg;
    assign out_neg_y = negy_reg;
    assign out_dmag  = dmag_reg;

endmodule

FILE: design/siu_divide.sv
`timescale 1ns / 1ps

module siu_divide import siu_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int EXTRA_FRAC_BITS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  siu_flags_t                     in_flags,
    input  logic [3*COORD_BITS+4+EXTRA_FRAC_BITS:0] num_x,
    input  logic [3*COORD_BITS+4+EXTRA_FRAC_BITS:0] num_y,
    input  logic                           neg_x,
    input  logic                           neg_y,
    input  logic [2*COORD_BITS+2:0]        dmag,
    output logic                           out_valid,
    output siu_flags_t                     out_flags,
    output logic signed [QUOT_BITS-1:0]    cross_x,
    output logic signed [QUOT_BITS-1:0]    cross_y
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int NW = 3 * C + 5 + EXTRA_FRAC_BITS;
    localparam int XW = NW + QUOT_BITS;
    localparam int Q  = QUOT_BITS;

    logic [Q+1:0] v_reg;

    // stage 0 is setup, stages 1..Q are one quotient bit each
    logic [DW-1:0]   rem_reg [Q+1][2];
    logic [Q-1:0]    lo_reg  [Q+1][2];
    logic [Q-1:0]    q_reg   [Q+1][2];
    logic            ovf_reg [Q+1][2];
    logic            neg_reg [Q+1][2];
    logic [DW-1:0]   d_reg   [Q+1];
    siu_flags_t      fl_reg  [Q+1];
    siu_flags_t      flo_reg;
    logic signed [Q-1:0] cx_reg, cy_reg;

    logic [XW-1:0]   wide_in [2];
    logic [NW-1:0]   hi_in   [2];
    logic [NW-1:0]   num_in  [2];
    logic            neg_in  [2];
    logic [DW:0]     trial   [Q][2];
    logic            ge      [Q][2];
    logic [Q-1:0]    res     [2];

    always_comb begin
        num_in[0] = num_x;
        num_in[1] = num_y;
        neg_in[0] = neg_x;
        neg_in[1] = neg_y;
        for (int l = 0; l < 2; l++) begin
            wide_in[l] = XW'(num_in[l]);
            hi_in[l]   = wide_in[l][XW-1:Q];
        end
        for (int k = 0; k < Q; k++) begin
            for (int l = 0; l < 2; l++) begin
                trial[k][l] = {rem_reg[k][l], lo_reg[k][l][Q-1]};
                ge[k][l]    = (trial[k][l] >= (DW+1)'(d_reg[k]));
            end
        end
        // zero for parallel, sign and saturation
        for (int l = 0; l < 2; l++) begin
            if (fl_reg[Q].par) begin
                res[l] = '0;
            end else if (!neg_reg[Q][l]) begin
                res[l] = (ovf_reg[Q][l] || q_reg[Q][l] > SAT_POS) ? SAT_POS : q_reg[Q][l];
            end else begin
                res[l] = (ovf_reg[Q][l] || q_reg[Q][l] > SAT_NEG) ? SAT_NEG : (-q_reg[Q][l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Q:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0]  <= dmag;
            fl_reg[0] <= in_flags;
            for (int l = 0; l < 2; l++) begin
                ovf_reg[0][l] <= (hi_in[l] >= NW'(dmag));
                rem_reg[0][l] <= hi_in[l][DW-1:0];
                lo_reg[0][l]  <= wide_in[l][Q-1:0];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg_in[l];
            end
            for (int k = 0; k < Q; k++) begin
                d_reg[k+1]  <= d_reg[k];
                fl_reg[k+1] <= fl_reg[k];
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k+1][l] <= ge[k][l] ? DW'(trial[k][l] - (DW+1)'(d_reg[k]))
                                                : DW'(trial[k][l]);
                    lo_reg[k+1][l]  <= {lo_reg[k][l][Q-2:0], 1'b0};
                    q_reg[k+1][l]   <= {q_reg[k][l][Q-2:0], ge[k][l]};
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                    neg_reg[k+1][l] <= neg_reg[k][l];
                end
            end
            cx_reg  <= res[0];
            cy_reg  <= res[1];
            flo_reg <= fl_reg[Q];
        end
    end

    assign out_valid = v_reg[Q+1];
    assign out_flags = flo_reg;
    assign cross_x   = cx_reg;
    assign cross_y   = cy_reg;

endmodule

FILE: design/segment_intersection_unit.sv
`timescale 1ns / 1ps
// channel   | ports                          | direction
// s_ (pair) | s_valid s_ready s_a_x1..s_b_y2 | in
// m_ (hit)  | m_valid m_ready m_hit m_parallel m_cross_x m_cross_y | out
//
// one word per cycle while the output is not stalled; pipeline: solve, projection, divider
// the divider resolves one quotient bit per stage over 32 stages per lane
// synchronous active-low reset clears the valid bits only
// a stalled output freezes the whole pipeline, nothing is lost or repeated

module segment_intersection_unit import siu_pkg::*; #(
    parameter int COORD_BITS      = 16,
    parameter int EXTRA_FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_a_x1,
    input  logic signed [COORD_BITS-1:0]  s_a_y1,
    input  logic signed [COORD_BITS-1:0]  s_a_x2,
    input  logic signed [COORD_BITS-1:0]  s_a_y2,
    input  logic signed [COORD_BITS-1:0]  s_b_x1,
    input  logic signed [COORD_BITS-1:0]  s_b_y1,
    input  logic signed [COORD_BITS-1:0]  s_b_x2,
    input  logic signed [COORD_BITS-1:0]  s_b_y2,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_parallel,
    output logic signed [QUOT_BITS-1:0]   m_cross_x,
    output logic signed [QUOT_BITS-1:0]   m_cross_y
);

    localparam int C  = COORD_BITS;
    localparam int DW = 2 * C + 3;
    localparam int NW = 3 * C + 5 + EXTRA_FRAC_BITS;

    logic en;

    logic                 sv_valid;
    siu_flags_t           sv_flags;
    logic signed [DW-1:0] sv_det, sv_t1;
    logic signed [DW:0]   sv_dt;
    logic signed [C-1:0]  sv_x1, sv_x2, sv_y1, sv_y2;

    logic          pj_valid;
    siu_flags_t    pj_flags;
    logic [NW-1:0] pj_nx, pj_ny;
    logic          pj_negx, pj_negy;
    logic [DW-1:0] pj_dmag;

    siu_flags_t    dv_flags;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    siu_solve #(.COORD_BITS(COORD_BITS)) u_solve (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s_valid),
        .a_x1(s_a_x1), .a_y1(s_a_y1), .a_x2(s_a_x2), .a_y2(s_a_y2),
        .b_x1(s_b_x1), .b_y1(s_b_y1), .b_x2(s_b_x2), .b_y2(s_b_y2),
        .out_valid(sv_valid), .out_flags(sv_flags),
        .out_det(sv_det), .out_t1(sv_t1), .out_dt(sv_dt),
        .out_x1(sv_x1), .out_x2(sv_x2), .out_y1(sv_y1), .out_y2(sv_y2)
    );

    siu_project #(.COORD_BITS(COORD_BITS), .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_project (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sv_valid),
        .in_flags(sv_flags), .det(sv_det), .t1(sv_t1), .dt(sv_dt),
        .x1(sv_x1), .x2(sv_x2), .y1(sv_y1), .y2(sv_y2),
        .out_valid(pj_valid), .out_flags(pj_flags),
        .out_num_x(pj_nx), .out_num_y(pj_ny),
        .out_neg_x(pj_negx), .out_neg_y(pj_negy), .out_dmag(pj_dmag)
    );

    siu_divide #(.COORD_BITS(COORD_BITS), .EXTRA_FRAC_BITS(EXTRA_FRAC_BITS)) u_divide (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(pj_valid),
        .in_flags(pj_flags), .num_x(pj_nx), .num_y(pj_ny),
        .neg_x(pj_negx), .neg_y(pj_negy), .dmag(pj_dmag),
        .out_valid(m_valid), .out_flags(dv_flags),
        .cross_x(m_cross_x), .cross_y(m_cross_y)
    );

    assign m_hit      = dv_flags.hit;
    assign m_parallel = dv_flags.par;

endmodule

FILE: design/siu_checker.sv
`timescale 1ns / 1ps

module siu_checker import siu_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_parallel,
    input logic [QUOT_BITS-1:0] m_cross_x,
    input logic [QUOT_BITS-1:0] m_cross_y
);

    a_par_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_parallel |-> m_cross_x == '0 && m_cross_y == '0)
        else $error("parallel word with nonzero point");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    a_free_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("ready low with empty output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cross_x) && $stable(m_cross_y))
        else $error("stalled word changed");

endmodule

bind segment_intersection_unit siu_checker u_siu_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_parallel(m_parallel),
    .m_cross_x(m_cross_x), .m_cross_y(m_cross_y)
);
